// File: rtl/core/qvfr_pkg.sv
// Package for the quadtree velocity/force refine core.
// Holds widths, register indexes, saturation and gain-multiply helpers.
package qvfr_pkg;
  localparam int MASK_KINDS = 16;
  localparam int VEC_BITS = 16;
  localparam int KIND_BITS = 4;
  localparam int TBL_DEPTH = MASK_KINDS * 4;
  localparam int TBL_ABITS = $clog2(TBL_DEPTH);
  localparam int SUM_BITS = VEC_BITS + 2;
  localparam int SQ_BITS = 2 * SUM_BITS + 1;
  localparam int LEN_BITS = SUM_BITS + 1;
  localparam int LVL_BITS = 18;

  typedef enum logic [2:0] {
    REG_FORCE_GAIN = 3'd0,
    REG_VEL_GAIN = 3'd1,
    REG_LAM_GAIN = 3'd2,
    REG_TURB_GAIN = 3'd3,
    REG_TURB_LEVEL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] force_gain;
    logic [15:0] velocity_gain;
    logic [15:0] laminar_gain;
    logic [15:0] turbulent_gain;
    logic [LVL_BITS-1:0] turbulence_level;
  } cfg_t;

  // round half up of a*g/2^14, a up to 24 bits signed
  function automatic logic signed [25:0] gmul(input logic signed [23:0] a,
                                              input logic signed [15:0] g);
    logic signed [40:0] p;
    begin
      p = 41'(a) * 41'(g) + 41'sd8192;
      gmul = 26'(p >>> 14);
    end
  endfunction

  function automatic logic signed [VEC_BITS-1:0] sat(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    begin
      hi = 28'((1 <<< (VEC_BITS - 1)) - 1);
      lo = -hi - 28'sd1;
      if (v > hi) sat = VEC_BITS'(hi);
      else if (v < lo) sat = VEC_BITS'(lo);
      else sat = VEC_BITS'(v);
    end
  endfunction
endpackage

// File: rtl/core/qvfr_if.sv
// Valid/ready channel interfaces for the refine core.
// Vector fields are declared with fixed 16-bit widths, without reference to qvfr_pkg.
interface qvfr_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [3:0] cell_kind;
  logic [1:0] mask_slot;
  logic [31:0] mask_xy;
  logic signed [15:0] parent_force_x;
  logic signed [15:0] parent_force_y;
  logic signed [15:0] parent_vel_x;
  logic signed [15:0] parent_vel_y;
  logic [31:0] old_vel_child0;
  logic [31:0] old_vel_child1;
  logic [31:0] old_vel_child2;
  logic [31:0] old_vel_child3;
  modport source(output valid, mode, cell_kind, mask_slot, mask_xy, parent_force_x,
    parent_force_y, parent_vel_x, parent_vel_y, old_vel_child0, old_vel_child1,
    old_vel_child2, old_vel_child3, input ready);
  modport sink(input valid, mode, cell_kind, mask_slot, mask_xy, parent_force_x,
    parent_force_y, parent_vel_x, parent_vel_y, old_vel_child0, old_vel_child1,
    old_vel_child2, old_vel_child3, output ready);
endinterface

interface qvfr_out_if;
  logic valid;
  logic ready;
  logic [1:0] child_index;
  logic signed [15:0] child_force_x;
  logic signed [15:0] child_force_y;
  logic signed [15:0] child_vel_x;
  logic signed [15:0] child_vel_y;
  logic last_child;
  modport source(output valid, child_index, child_force_x, child_force_y, child_vel_x,
    child_vel_y, last_child, input ready);
  modport sink(input valid, child_index, child_force_x, child_force_y, child_vel_x,
    child_vel_y, last_child, output ready);
endinterface

// File: rtl/core/qvfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qvfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input logic clk,
  input logic we,
  input logic [$clog2(DEPTH)-1:0] waddr,
  input logic [WIDTH-1:0] wdata,
  input logic re,
  input logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/qvfr_isqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on qvfr_pkg; stalls with the shared enable.
module qvfr_isqrt (
  input logic clk,
  input logic en,
  input logic [qvfr_pkg::SQ_BITS+1:0] n_in,
  output logic [qvfr_pkg::LEN_BITS-1:0] root
);
  import qvfr_pkg::*;
  localparam int NB = SQ_BITS + 2;   // odd
  localparam int ST = NB / 2;
  localparam int STG = (ST + 1) / 2;

  logic [NB-1:0] rem [STG+1];
  logic [NB-1:0] rt [STG+1];
  logic [NB-1:0] rem_c [STG][3];
  logic [NB-1:0] rt_c [STG][3];

  assign rem[0] = n_in;
  assign rt[0] = '0;

  for (genvar s = 0; s < STG; s++) begin : g_st
    assign rem_c[s][0] = rem[s];
    assign rt_c[s][0] = rt[s];
    for (genvar j = 0; j < 2; j++) begin : g_bit
      localparam int I = 2 * s + j;
      localparam int SH = 2 * (ST - 1 - I);
      logic [NB-1:0] trial;
      if (I < ST) begin : g_do
        assign trial = rt_c[s][j] + (NB'(1) << SH);
        always_comb begin
          if (rem_c[s][j] >= trial) begin
            rem_c[s][j+1] = rem_c[s][j] - trial;
            rt_c[s][j+1] = (rt_c[s][j] >> 1) + (NB'(1) << SH);
          end else begin
            rem_c[s][j+1] = rem_c[s][j];
            rt_c[s][j+1] = rt_c[s][j] >> 1;
          end
        end
      end else begin : g_skip
        assign trial = '0;
        assign rem_c[s][j+1] = rem_c[s][j] | trial;
        assign rt_c[s][j+1] = rt_c[s][j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_c[s][2];
        rt[s+1] <= rt_c[s][2];
      end
    end
  end

  assign root = LEN_BITS'(rt[STG]);
endmodule

// File: rtl/core/qvfr_pipe.sv
// Refine datapath: mask table, gain products, velocity sum, length, regime.
// Depends on qvfr_pkg, qvfr_ram and qvfr_isqrt; one cell enters per enable.
module qvfr_pipe (
  input logic clk,
  input logic rst,
  input logic en,
  input logic in_valid,
  input logic in_mode,
  input logic [3:0] in_kind,
  input logic [1:0] in_slot,
  input logic [31:0] in_mask,
  input logic signed [15:0] in_pfx,
  input logic signed [15:0] in_pfy,
  input logic signed [15:0] in_pvx,
  input logic signed [15:0] in_pvy,
  input logic [127:0] in_ov,
  input qvfr_pkg::cfg_t cfg,
  output logic out_valid,
  output logic [255:0] out_vec,
  output logic [3:0] out_busy
);
  import qvfr_pkg::*;
  localparam int SQ_STG = (SQ_BITS + 3) / 4;

  // stage 1: table read, velocity gain
  logic v1;
  logic kind_ok1;
  logic signed [15:0] pfx1, pfy1;
  logic signed [25:0] dvx1, dvy1;
  logic [127:0] ov1;
  logic [127:0] mask_rd;
  logic kind_ok;
  assign kind_ok = 32'(in_kind) < MASK_KINDS;

  for (genvar k = 0; k < 4; k++) begin : g_tbl
    qvfr_ram #(.WIDTH(32), .DEPTH(MASK_KINDS)) u_ram (
      .clk(clk),
      .we(en && in_valid && in_mode && kind_ok && in_slot == 2'(k)),
      .waddr(in_kind), .wdata(in_mask),
      .re(en), .raddr(in_kind), .rdata(mask_rd[32*k +: 32])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid && !in_mode;
    if (en) begin
      kind_ok1 <= kind_ok;
      pfx1 <= in_pfx;
      pfy1 <= in_pfy;
      ov1 <= in_ov;
      dvx1 <= gmul(24'(in_pvx), cfg.velocity_gain);
      dvy1 <= gmul(24'(in_pvy), cfg.velocity_gain);
    end
  end

  // stage 2: forces, first velocities
  logic v2;
  logic signed [15:0] fx2 [4], fy2 [4], vx2 [4], vy2 [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic [31:0] m;
        m = kind_ok1 ? mask_rd[32*k +: 32] : 32'd0;
        fx2[k] <= sat(28'(pfx1) + 28'(gmul(24'($signed(m[31:16])), cfg.force_gain)));
        fy2[k] <= sat(28'(pfy1) + 28'(gmul(24'($signed(m[15:0])), cfg.force_gain)));
        vx2[k] <= sat(28'($signed(ov1[32*k+16 +: 16])) + 28'(dvx1));
        vy2[k] <= sat(28'($signed(ov1[32*k +: 16])) + 28'(dvy1));
      end
    end
  end

  // stage 3: sums
  logic v3;
  logic signed [15:0] fx3 [4], fy3 [4], vx3 [4], vy3 [4];
  logic signed [SUM_BITS-1:0] sx3, sy3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      fx3 <= fx2; fy3 <= fy2; vx3 <= vx2; vy3 <= vy2;
      sx3 <= SUM_BITS'(vx2[0]) + SUM_BITS'(vx2[1]) + SUM_BITS'(vx2[2]) + SUM_BITS'(vx2[3]);
      sy3 <= SUM_BITS'(vy2[0]) + SUM_BITS'(vy2[1]) + SUM_BITS'(vy2[2]) + SUM_BITS'(vy2[3]);
    end
  end

  // stage 4: squares, laminar gain products
  logic v4;
  logic signed [15:0] fx4 [4], fy4 [4], vx4 [4], vy4 [4];
  logic signed [25:0] ax4, ay4;
  logic [SQ_BITS-1:0] sq4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      fx4 <= fx3; fy4 <= fy3; vx4 <= vx3; vy4 <= vy3;
      sq4 <= SQ_BITS'($unsigned((2*SUM_BITS)'(sx3) * (2*SUM_BITS)'(sx3)))
           + SQ_BITS'($unsigned((2*SUM_BITS)'(sy3) * (2*SUM_BITS)'(sy3)));
      ax4 <= gmul(24'(sx3), cfg.laminar_gain);
      ay4 <= gmul(24'(sy3), cfg.laminar_gain);
    end
  end

  // square root stages, data delayed alongside
  logic [LEN_BITS-1:0] len;
  qvfr_isqrt u_sqrt (.clk(clk), .en(en), .n_in((SQ_BITS+2)'(sq4)), .root(len));

  logic [SQ_STG:0] vd;
  logic [255:0] dly [SQ_STG+1];
  logic [51:0] adly [SQ_STG+1];
  always_comb begin
    for (int k = 0; k < 4; k++)
      dly[0][64*k +: 64] = {fx4[k], fy4[k], vx4[k], vy4[k]};
  end
  assign adly[0] = {ax4, ay4};
  assign vd[0] = v4;
  for (genvar s = 0; s < SQ_STG; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) vd[s+1] <= 1'b0;
      else if (en) vd[s+1] <= vd[s];
      if (en) begin
        dly[s+1] <= dly[s];
        adly[s+1] <= adly[s];
      end
    end
  end

  // turbulent product stage
  logic vt;
  logic lam;
  logic signed [25:0] ht;
  logic [255:0] dt;
  logic [51:0] at;
  always_ff @(posedge clk) begin
    if (rst) vt <= 1'b0;
    else if (en) vt <= vd[SQ_STG];
    if (en) begin
      lam <= 32'(len) < 32'(cfg.turbulence_level);
      ht <= gmul(24'(len), cfg.turbulent_gain);
      dt <= dly[SQ_STG];
      at <= adly[SQ_STG];
    end
  end

  // final adds
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vt;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [27:0] ex, ey;
        if (lam) begin
          ex = 28'($signed(at[51:26]));
          ey = 28'($signed(at[25:0]));
        end else begin
          ex = (k % 2 == 1) ? 28'(ht) : -28'(ht);
          ey = (k >= 2) ? 28'(ht) : -28'(ht);
        end
        out_vec[64*k +: 64] <= {dt[64*k+48 +: 16], dt[64*k+32 +: 16],
          sat(28'($signed(dt[64*k+16 +: 16])) + ex),
          sat(28'($signed(dt[64*k +: 16])) + ey)};
      end
    end
  end

  assign out_busy = {v1 | v2, v3 | v4, |vd, vt};

  check_len: assert property (@(posedge clk) disable iff (rst)
    en && !in_valid |=> !v1) else $error("stage 1 valid without transfer");
  check_mode: assert property (@(posedge clk) disable iff (rst)
    en && in_valid && in_mode |=> !v1) else $error("table load entered datapath");
  check_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid)) else $error("output valid moved during stall");
endmodule

// File: rtl/core/quadtree_velocity_force_refine_core.sv
// Top level of the quadtree velocity/force refine core.
// Each cell's children leave through the four-transfer output serializer, which holds one cell;
// the pipeline advances whenever that output slot is free or its last stage holds no valid cell,
// so new cells and table loads can be accepted while the serializer is still emitting children.
// Reset (rst, synchronous) clears valids and restores register defaults;
// the mask table is undefined until loaded.
module quadtree_velocity_force_refine_core (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [17:0] cfg_data,
  qvfr_in_if.sink in_ch,
  qvfr_out_if.source out_ch
);
  import qvfr_pkg::*;

  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_gain <= 16'sd16384;
      cfg.velocity_gain <= 16'sd16384;
      cfg.laminar_gain <= '0;
      cfg.turbulent_gain <= '0;
      cfg.turbulence_level <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORCE_GAIN: cfg.force_gain <= cfg_data[15:0];
        REG_VEL_GAIN: cfg.velocity_gain <= cfg_data[15:0];
        REG_LAM_GAIN: cfg.laminar_gain <= cfg_data[15:0];
        REG_TURB_GAIN: cfg.turbulent_gain <= cfg_data[15:0];
        REG_TURB_LEVEL: cfg.turbulence_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // serializer: holds one cell, emits four children
  logic hold;
  logic [1:0] idx;
  logic [255:0] buf_vec;
  logic p_valid;
  logic [255:0] p_vec;
  logic [3:0] busy;
  logic done;
  logic en;

  assign done = hold && out_ch.ready && idx == 2'd3;
  assign en = !hold || done || !p_valid;
  assign in_ch.ready = en;

  qvfr_pipe u_pipe (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_ch.valid), .in_mode(in_ch.mode), .in_kind(in_ch.cell_kind),
    .in_slot(in_ch.mask_slot), .in_mask(in_ch.mask_xy),
    .in_pfx(in_ch.parent_force_x), .in_pfy(in_ch.parent_force_y),
    .in_pvx(in_ch.parent_vel_x), .in_pvy(in_ch.parent_vel_y),
    .in_ov({in_ch.old_vel_child3, in_ch.old_vel_child2,
            in_ch.old_vel_child1, in_ch.old_vel_child0}),
    .cfg(cfg), .out_valid(p_valid), .out_vec(p_vec), .out_busy(busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
      idx <= '0;
    end else begin
      if (hold && out_ch.ready) idx <= idx + 2'd1;
      if (en && p_valid) begin
        hold <= 1'b1;
        buf_vec <= p_vec;
      end else if (done) begin
        hold <= 1'b0;
      end
    end
  end

  assign out_ch.valid = hold;
  assign out_ch.child_index = idx;
  assign out_ch.child_force_x = buf_vec[64*idx+48 +: 16];
  assign out_ch.child_force_y = buf_vec[64*idx+32 +: 16];
  assign out_ch.child_vel_x = buf_vec[64*idx+16 +: 16];
  assign out_ch.child_vel_y = buf_vec[64*idx +: 16];
  assign out_ch.last_child = idx == 2'd3;

  check_idx: assert property (@(posedge clk) disable iff (rst)
    !hold |-> idx == 2'd0) else $error("child index not zero when empty");
  check_busy: assert property (@(posedge clk) disable iff (rst)
    hold && !out_ch.ready |=> hold && $stable(idx)) else $error("stalled child lost");
  check_en: assert property (@(posedge clk) disable iff (rst)
    p_valid && hold && !done |-> !en) else $error("pipe advanced over full buffer");
  check_ld: assert property (@(posedge clk) disable iff (rst)
    !(|busy) && !hold |-> en) else $error("idle core not ready");
endmodule

// File: tb/sv/quadtree_velocity_force_refine_core_tb.sv
// Testbench for quadtree_velocity_force_refine_core: mask loads and cell refines
// checked against an in-bench fixed-point predictor of the four child results.
// Depends on qvfr_pkg and the qvfr_in_if / qvfr_out_if channel interfaces.
`timescale 1ns / 100ps

module quadtree_velocity_force_refine_core_tb;
  import qvfr_pkg::*;

  typedef struct {
    bit mode;
    bit [3:0] kind;
    bit [1:0] slot;
    bit [31:0] mask_xy;
    bit [15:0] pfx;
    bit [15:0] pfy;
    bit [15:0] pvx;
    bit [15:0] pvy;
    bit [31:0] ov0;
    bit [31:0] ov1;
    bit [31:0] ov2;
    bit [31:0] ov3;
  } cell_item_t;

  typedef struct {
    cell_item_t it;
    bit typed;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] idx;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] vx;
    logic [15:0] vy;
    logic last;
  } child_res_t;

  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [17:0] cfg_data;

  qvfr_in_if in_ch();
  qvfr_out_if out_ch();

  quadtree_velocity_force_refine_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  logic [31:0] mask_copy [TBL_DEPTH];
  bit slot_loaded [TBL_DEPTH];
  longint g_force, g_vel, g_lam, g_turb;
  longint unsigned turb_level;

  child_res_t expected_children[$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;
  bit long_hold_done;
  int hold_count;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint sx16(input bit [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint q14_mul(input longint a, input longint g);
    longint p;
    p = a * g + 64'sd8192;
    return p >>> 14;
  endfunction

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // apply one accepted item to the predictor
  task automatic predict_cell(input cell_item_t it, input bit typed);
    longint fx[4], fy[4], vx[4], vy[4];
    longint dvx, dvy, sumx, sumy, ax, ay, h;
    longint unsigned len;
    bit [31:0] ov[4];
    bit [31:0] m;
    child_res_t r;
    int signs_x[4];
    int signs_y[4];
    signs_x = '{-1, 1, -1, 1};
    signs_y = '{-1, -1, 1, 1};
    if (it.mode) begin
      mask_copy[{it.kind, it.slot}] = it.mask_xy;
      slot_loaded[{it.kind, it.slot}] = 1'b1;
      return;
    end
    ov = '{it.ov0, it.ov1, it.ov2, it.ov3};
    dvx = q14_mul(sx16(it.pvx), g_vel);
    dvy = q14_mul(sx16(it.pvy), g_vel);
    sumx = 0;
    sumy = 0;
    for (int k = 0; k < 4; k++) begin
      m = mask_copy[{it.kind, k[1:0]}];
      fx[k] = sat16(sx16(it.pfx) + q14_mul(sx16(m[31:16]), g_force));
      fy[k] = sat16(sx16(it.pfy) + q14_mul(sx16(m[15:0]), g_force));
      vx[k] = sat16(sx16(ov[k][31:16]) + dvx);
      vy[k] = sat16(sx16(ov[k][15:0]) + dvy);
      sumx += vx[k];
      sumy += vy[k];
    end
    len = int_sqrt(longint'(sumx * sumx) + longint'(sumy * sumy));
    if (len < turb_level) begin
      ax = q14_mul(sumx, g_lam);
      ay = q14_mul(sumy, g_lam);
      for (int k = 0; k < 4; k++) begin
        vx[k] = sat16(vx[k] + ax);
        vy[k] = sat16(vy[k] + ay);
      end
    end else begin
      h = q14_mul(longint'(len), g_turb);
      for (int k = 0; k < 4; k++) begin
        vx[k] = sat16(vx[k] + signs_x[k] * h);
        vy[k] = sat16(vy[k] + signs_y[k] * h);
      end
    end
    for (int k = 0; k < 4; k++) begin
      r.idx = k[1:0];
      r.last = (k == 3);
      if (typed) begin
        r.fx = '0; r.fy = '0; r.vx = '0; r.vy = '0;
      end else begin
        r.fx = fx[k][15:0];
        r.fy = fy[k][15:0];
        r.vx = vx[k][15:0];
        r.vy = vy[k][15:0];
      end
      expected_children.push_back(r);
    end
  endtask

  task automatic send_cell(input cell_item_t it, input bit typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.cell_kind <= it.kind;
    in_ch.mask_slot <= it.slot;
    in_ch.mask_xy <= it.mask_xy;
    in_ch.parent_force_x <= it.pfx;
    in_ch.parent_force_y <= it.pfy;
    in_ch.parent_vel_x <= it.pvx;
    in_ch.parent_vel_y <= it.pvy;
    in_ch.old_vel_child0 <= it.ov0;
    in_ch.old_vel_child1 <= it.ov1;
    in_ch.old_vel_child2 <= it.ov2;
    in_ch.old_vel_child3 <= it.ov3;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cell(it, typed);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FORCE_GAIN: g_force = sx16(val[15:0]);
      REG_VEL_GAIN: g_vel = sx16(val[15:0]);
      REG_LAM_GAIN: g_lam = sx16(val[15:0]);
      REG_TURB_GAIN: g_turb = sx16(val[15:0]);
      REG_TURB_LEVEL: turb_level = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_children.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gains(input logic [15:0] fg, input logic [15:0] vg,
                           input logic [15:0] lg, input logic [15:0] tg,
                           input logic [17:0] lvl);
    write_reg(REG_FORCE_GAIN, {2'b00, fg});
    write_reg(REG_VEL_GAIN, {2'b00, vg});
    write_reg(REG_LAM_GAIN, {2'b00, lg});
    write_reg(REG_TURB_GAIN, {2'b00, tg});
    write_reg(REG_TURB_LEVEL, lvl);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(63));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit kind_ready(input bit [3:0] kd);
    for (int s = 0; s < 4; s++) if (!slot_loaded[{kd, s[1:0]}]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic random_run(input int n);
    cell_item_t it;
    bit [3:0] kd;
    for (int i = 0; i < n; i++) begin
      it.mode = ($urandom_range(99) < 25);
      kd = 4'($urandom);
      if (!it.mode) begin
        while (!kind_ready(kd)) kd = 4'($urandom);
      end
      it.kind = kd;
      it.slot = 2'($urandom);
      it.mask_xy = {pick16(), pick16()};
      it.pfx = pick16();
      it.pfy = pick16();
      it.pvx = pick16();
      it.pvy = pick16();
      it.ov0 = {pick16(), pick16()};
      it.ov1 = {pick16(), pick16()};
      it.ov2 = {pick16(), pick16()};
      it.ov3 = {pick16(), pick16()};
      send_cell(it, 1'b0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    child_res_t got;
    child_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.child_index, out_ch.child_force_x, out_ch.child_force_y,
             out_ch.child_vel_x, out_ch.child_vel_y, out_ch.last_child};
      if (expected_children.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected child result %h", got);
      end else begin
        want = expected_children.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"child mismatch: expected idx %0d f(%h,%h) v(%h,%h) last %b,",
                      " got idx %0d f(%h,%h) v(%h,%h) last %b"},
                     want.idx, want.fx, want.fy, want.vx, want.vy, want.last,
                     got.idx, got.fx, got.fy, got.vx, got.vy, got.last);
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      out_ch.ready <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    cell_item_t z;
    z = '{1'b0, 4'd0, 2'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    hold_count = 0;
    g_force = 16384;
    g_vel = 16384;
    g_lam = 0;
    g_turb = 0;
    turb_level = 262143;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_FORCE_GAIN;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= 1'b0;
    in_ch.cell_kind <= '0;
    in_ch.mask_slot <= '0;
    in_ch.mask_xy <= '0;
    in_ch.parent_force_x <= '0;
    in_ch.parent_force_y <= '0;
    in_ch.parent_vel_x <= '0;
    in_ch.parent_vel_y <= '0;
    in_ch.old_vel_child0 <= '0;
    in_ch.old_vel_child1 <= '0;
    in_ch.old_vel_child2 <= '0;
    in_ch.old_vel_child3 <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load kind 0 with zero masks, then an all-zero refine under reset gains
    for (int s = 0; s < 4; s++)
      rows.push_back('{'{1'b1, 4'd0, 2'(s), 32'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                        32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{z, 1'b1});
    // kind 15 with extreme masks
    rows.push_back('{'{1'b1, 4'd15, 2'd0, 32'h7FFF7FFF, 16'd0, 16'd0, 16'd0, 16'd0,
                      32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd15, 2'd1, 32'h80008000, 16'd0, 16'd0, 16'd0, 16'd0,
                      32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd15, 2'd2, 32'h7FFF8000, 16'd0, 16'd0, 16'd0, 16'd0,
                      32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd15, 2'd3, 32'h80007FFF, 16'd0, 16'd0, 16'd0, 16'd0,
                      32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b0, 4'd15, 2'd3, 32'hFFFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF,
                      32'h7FFF7FFF}, 1'b0});
    rows.push_back('{'{1'b0, 4'd15, 2'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 32'h80008000, 32'h80008000, 32'h80008000,
                      32'h80008000}, 1'b0});
    rows.push_back('{'{1'b0, 4'd15, 2'd1, 32'd0, 16'h7FFF, 16'h8000, 16'h8000,
                      16'h7FFF, 32'h7FFF8000, 32'h80007FFF, 32'h00010001,
                      32'hFFFFFFFF}, 1'b0});
    rows.push_back('{'{1'b0, 4'd0, 2'd2, 32'd0, 16'h0400, 16'hFC00, 16'h0001,
                      16'hFFFF, 32'h04000400, 32'hFC00FC00, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, 2'd1, 32'h12345678, 16'd0, 16'd0, 16'd0, 16'd0,
                      32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
    rows.push_back('{'{1'b0, 4'd0, 2'd0, 32'd0, 16'h0100, 16'hFF00, 16'h0200,
                      16'hFE00, 32'h01000100, 32'h00200020, 32'h0, 32'h0}, 1'b0});
    foreach (rows[i]) send_cell(rows[i].it, rows[i].typed);
    wait_idle();

    // turbulent everywhere: level zero, top gains
    set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 18'd0);
    foreach (rows[i]) if (!rows[i].it.mode) send_cell(rows[i].it, 1'b0);
    random_run(25);
    wait_idle();

    send_idle_pct = 66;
    set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 18'd2000);
    random_run(25);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 66;
    set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              18'($urandom_range(262143)));
    long_hold_req = 1'b1;
    random_run(25);
    wait_idle();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    set_gains(16'h2000, 16'hC000, 16'h1000, 16'hE000, 18'h3FFFF);
    random_run(25);
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
